@@ src/psca_pkg.sv @@
// shared types, codes and reset values of the per-source credit admission unit
package psca_pkg;

  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 48;
  localparam int CTX_W        = 8;
  localparam int GBEAT_W      = 12;
  localparam int BURST_W      = 9;
  localparam int CTX_WORD_W   = 32;
  localparam int BEAT_WORD_W  = 48;
  localparam int SRC_IDX_W    = 2;

  localparam logic [CTX_W-1:0]       RST_CTX_CAP   = 8'd16;
  localparam logic [GBEAT_W-1:0]     RST_BEAT_CAP  = 12'd256;
  localparam logic [CTX_WORD_W-1:0]  RST_CTX_LIMS  = 32'h0404_0404;
  localparam logic [BEAT_WORD_W-1:0] RST_BEAT_LIMS = 48'h1001_0010_0100;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_RESERVE = 2'd1,
    OP_RELEASE = 2'd2
  } psca_op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_REFUSED    = 2'd1,
    ST_UNDERFLOW  = 2'd2,
    ST_OVER_LIMIT = 2'd3
  } psca_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WR_CTX_CAP  = 3'd0,
    REG_WR_BEAT_CAP = 3'd1,
    REG_RD_CTX_CAP  = 3'd2,
    REG_RD_BEAT_CAP = 3'd3,
    REG_WR_CTX_LIM  = 3'd4,
    REG_WR_BEAT_LIM = 3'd5,
    REG_RD_CTX_LIM  = 3'd6,
    REG_RD_BEAT_LIM = 3'd7
  } psca_reg_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic                 is_read;
    logic [SRC_IDX_W-1:0] source_index;
    logic [BURST_W-1:0]   burst_beats;
  } psca_req_t;

  typedef struct packed {
    logic         granted;
    psca_status_e status;
  } psca_rsp_t;

  // counter update command from the decision logic
  typedef struct packed {
    logic                 do_reserve;
    logic                 do_release;
    logic                 is_read;
    logic [SRC_IDX_W-1:0] source;
    logic [BURST_W-1:0]   beats;
  } psca_upd_t;

endpackage

@@ src/psca_cfg.sv @@
// configuration registers and per-source limit selection
module psca_cfg import psca_pkg::*; #(
  parameter int NUM_SOURCES = 4,
  parameter int BEAT_BITS   = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  is_read_i,
  input  logic [SRC_IDX_W-1:0]  source_i,
  output logic [CTX_W-1:0]      cap_ctx_o,
  output logic [GBEAT_W-1:0]    cap_beats_o,
  output logic [CTX_W-1:0]      lim_ctx_o,
  output logic [BEAT_BITS-1:0]  lim_beats_o
);

  logic [CTX_W-1:0]       wr_ctx_cap_q, rd_ctx_cap_q;
  logic [GBEAT_W-1:0]     wr_beat_cap_q, rd_beat_cap_q;
  logic [CTX_WORD_W-1:0]  wr_ctx_lim_q, rd_ctx_lim_q;
  logic [BEAT_WORD_W-1:0] wr_beat_lim_q, rd_beat_lim_q;

  logic [CTX_WORD_W-1:0]  ctx_word;
  logic [63:0]            beat_word;
  logic [CTX_W-1:0]       ctx_lim   [NUM_SOURCES];
  logic [BEAT_BITS-1:0]   beat_lim  [NUM_SOURCES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ctx_cap_q  <= RST_CTX_CAP;
      wr_beat_cap_q <= RST_BEAT_CAP;
      rd_ctx_cap_q  <= RST_CTX_CAP;
      rd_beat_cap_q <= RST_BEAT_CAP;
      wr_ctx_lim_q  <= RST_CTX_LIMS;
      wr_beat_lim_q <= RST_BEAT_LIMS;
      rd_ctx_lim_q  <= RST_CTX_LIMS;
      rd_beat_lim_q <= RST_BEAT_LIMS;
    end else if (cfg_we_i) begin
      case (psca_reg_e'(cfg_idx_i))
        REG_WR_CTX_CAP:  wr_ctx_cap_q  <= cfg_data_i[CTX_W-1:0];
        REG_WR_BEAT_CAP: wr_beat_cap_q <= cfg_data_i[GBEAT_W-1:0];
        REG_RD_CTX_CAP:  rd_ctx_cap_q  <= cfg_data_i[CTX_W-1:0];
        REG_RD_BEAT_CAP: rd_beat_cap_q <= cfg_data_i[GBEAT_W-1:0];
        REG_WR_CTX_LIM:  wr_ctx_lim_q  <= cfg_data_i[CTX_WORD_W-1:0];
        REG_WR_BEAT_LIM: wr_beat_lim_q <= cfg_data_i[BEAT_WORD_W-1:0];
        REG_RD_CTX_LIM:  rd_ctx_lim_q  <= cfg_data_i[CTX_WORD_W-1:0];
        REG_RD_BEAT_LIM: rd_beat_lim_q <= cfg_data_i[BEAT_WORD_W-1:0];
        default: ;
      endcase
    end
  end

  assign cap_ctx_o   = is_read_i ? rd_ctx_cap_q  : wr_ctx_cap_q;
  assign cap_beats_o = is_read_i ? rd_beat_cap_q : wr_beat_cap_q;
  assign ctx_word    = is_read_i ? rd_ctx_lim_q  : wr_ctx_lim_q;
  assign beat_word   = {{(64-BEAT_WORD_W){1'b0}}, (is_read_i ? rd_beat_lim_q : wr_beat_lim_q)};

  // fields past the end of a packed word read as zero
  for (genvar i = 0; i < NUM_SOURCES; i++) begin : g_lim
    if (CTX_W * (i + 1) <= CTX_WORD_W) begin : g_ctx_in
      assign ctx_lim[i] = ctx_word[CTX_W*i +: CTX_W];
    end else begin : g_ctx_out
      assign ctx_lim[i] = '0;
    end
    if (BEAT_BITS * i < 64) begin : g_beat_in
      assign beat_lim[i] = BEAT_BITS'(beat_word >> (BEAT_BITS * i));
    end else begin : g_beat_out
      assign beat_lim[i] = '0;
    end
  end

  always_comb begin
    lim_ctx_o   = '0;
    lim_beats_o = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (32'(source_i) == i) begin
        lim_ctx_o   = ctx_lim[i];
        lim_beats_o = beat_lim[i];
      end
    end
  end

endmodule

@@ src/psca_cnt.sv @@
// global and per-source context and beat counters
module psca_cnt import psca_pkg::*; #(
  parameter int NUM_SOURCES = 4,
  parameter int BEAT_BITS   = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 is_read_i,
  input  logic [SRC_IDX_W-1:0] source_i,
  input  psca_upd_t            upd_i,
  output logic [CTX_W-1:0]     g_ctx_o,
  output logic [GBEAT_W-1:0]   g_beats_o,
  output logic [CTX_W-1:0]     a_ctx_o,
  output logic [BEAT_BITS-1:0] a_beats_o
);

  logic [CTX_W-1:0]     tot_wr_ctx_q, tot_rd_ctx_q;
  logic [GBEAT_W-1:0]   tot_wr_beats_q, tot_rd_beats_q;
  logic [CTX_W-1:0]     src_wr_ctx_q   [NUM_SOURCES];
  logic [CTX_W-1:0]     src_rd_ctx_q   [NUM_SOURCES];
  logic [BEAT_BITS-1:0] src_wr_beats_q [NUM_SOURCES];
  logic [BEAT_BITS-1:0] src_rd_beats_q [NUM_SOURCES];

  logic [GBEAT_W-1:0]   g_delta;
  logic [BEAT_BITS-1:0] a_delta;

  assign g_delta = GBEAT_W'(upd_i.beats);
  assign a_delta = BEAT_BITS'(upd_i.beats);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot_wr_ctx_q   <= '0;
      tot_rd_ctx_q   <= '0;
      tot_wr_beats_q <= '0;
      tot_rd_beats_q <= '0;
      for (int i = 0; i < NUM_SOURCES; i++) begin
        src_wr_ctx_q[i]   <= '0;
        src_rd_ctx_q[i]   <= '0;
        src_wr_beats_q[i] <= '0;
        src_rd_beats_q[i] <= '0;
      end
    end else if (upd_i.do_reserve) begin
      if (upd_i.is_read) begin
        tot_rd_ctx_q   <= tot_rd_ctx_q + 8'd1;
        tot_rd_beats_q <= tot_rd_beats_q + g_delta;
      end else begin
        tot_wr_ctx_q   <= tot_wr_ctx_q + 8'd1;
        tot_wr_beats_q <= tot_wr_beats_q + g_delta;
      end
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (32'(upd_i.source) == i) begin
          if (upd_i.is_read) begin
            src_rd_ctx_q[i]   <= src_rd_ctx_q[i] + 8'd1;
            src_rd_beats_q[i] <= src_rd_beats_q[i] + a_delta;
          end else begin
            src_wr_ctx_q[i]   <= src_wr_ctx_q[i] + 8'd1;
            src_wr_beats_q[i] <= src_wr_beats_q[i] + a_delta;
          end
        end
      end
    end else if (upd_i.do_release) begin
      if (upd_i.is_read) begin
        tot_rd_ctx_q   <= tot_rd_ctx_q - 8'd1;
        tot_rd_beats_q <= tot_rd_beats_q - g_delta;
      end else begin
        tot_wr_ctx_q   <= tot_wr_ctx_q - 8'd1;
        tot_wr_beats_q <= tot_wr_beats_q - g_delta;
      end
      for (int i = 0; i < NUM_SOURCES; i++) begin
        if (32'(upd_i.source) == i) begin
          if (upd_i.is_read) begin
            src_rd_ctx_q[i]   <= src_rd_ctx_q[i] - 8'd1;
            src_rd_beats_q[i] <= src_rd_beats_q[i] - a_delta;
          end else begin
            src_wr_ctx_q[i]   <= src_wr_ctx_q[i] - 8'd1;
            src_wr_beats_q[i] <= src_wr_beats_q[i] - a_delta;
          end
        end
      end
    end
  end

  assign g_ctx_o   = is_read_i ? tot_rd_ctx_q   : tot_wr_ctx_q;
  assign g_beats_o = is_read_i ? tot_rd_beats_q : tot_wr_beats_q;

  always_comb begin
    a_ctx_o   = '0;
    a_beats_o = '0;
    for (int i = 0; i < NUM_SOURCES; i++) begin
      if (32'(source_i) == i) begin
        a_ctx_o   = is_read_i ? src_rd_ctx_q[i]   : src_wr_ctx_q[i];
        a_beats_o = is_read_i ? src_rd_beats_q[i] : src_wr_beats_q[i];
      end
    end
  end

endmodule

@@ src/psca_dec.sv @@
// admission decision: capacity, limit and underflow checks
module psca_dec import psca_pkg::*; #(
  parameter int NUM_SOURCES = 4,
  parameter int BEAT_BITS   = 12
) (
  input  logic                 valid_i,
  input  psca_req_t            req_i,
  input  logic [CTX_W-1:0]     g_ctx_i,
  input  logic [GBEAT_W-1:0]   g_beats_i,
  input  logic [CTX_W-1:0]     a_ctx_i,
  input  logic [BEAT_BITS-1:0] a_beats_i,
  input  logic [CTX_W-1:0]     cap_ctx_i,
  input  logic [GBEAT_W-1:0]   cap_beats_i,
  input  logic [CTX_W-1:0]     lim_ctx_i,
  input  logic [BEAT_BITS-1:0] lim_beats_i,
  output psca_rsp_t            rsp_o,
  output psca_upd_t            upd_o
);

  logic                 op_ok;
  logic                 src_ok;
  logic [GBEAT_W:0]     g_sum;
  logic [BEAT_BITS:0]   a_sum;
  logic [GBEAT_W-1:0]   g_burst;
  logic [BEAT_BITS-1:0] a_burst;

  assign op_ok   = req_i.operation inside {OP_QUERY, OP_RESERVE, OP_RELEASE};
  assign src_ok  = 32'(req_i.source_index) < NUM_SOURCES;
  assign g_burst = GBEAT_W'(req_i.burst_beats);
  assign a_burst = BEAT_BITS'(req_i.burst_beats);
  // sums carry one extra bit so the capacity compare never wraps
  assign g_sum   = {1'b0, g_beats_i} + {1'b0, g_burst};
  assign a_sum   = {1'b0, a_beats_i} + {1'b0, a_burst};

  always_comb begin
    rsp_o.granted    = 1'b0;
    rsp_o.status     = ST_REFUSED;
    upd_o.do_reserve = 1'b0;
    upd_o.do_release = 1'b0;
    upd_o.is_read    = req_i.is_read;
    upd_o.source     = req_i.source_index;
    upd_o.beats      = req_i.burst_beats;
    if (op_ok && src_ok) begin
      if (req_i.operation == OP_RELEASE) begin
        if (a_ctx_i == '0 || g_ctx_i == '0 || a_beats_i < a_burst || g_beats_i < g_burst) begin
          rsp_o.status = ST_UNDERFLOW;
        end else begin
          rsp_o.granted    = 1'b1;
          rsp_o.status     = ST_OK;
          upd_o.do_release = valid_i;
        end
      end else if (g_ctx_i >= cap_ctx_i || g_sum > {1'b0, cap_beats_i}) begin
        rsp_o.status = ST_REFUSED;
      end else if (a_ctx_i > lim_ctx_i || a_beats_i > lim_beats_i) begin
        rsp_o.status = ST_OVER_LIMIT;
      end else if (a_ctx_i >= lim_ctx_i || a_sum > {1'b0, lim_beats_i}) begin
        rsp_o.status = ST_REFUSED;
      end else begin
        rsp_o.granted    = 1'b1;
        rsp_o.status     = ST_OK;
        upd_o.do_reserve = valid_i && (req_i.operation == OP_RESERVE);
      end
    end
  end

endmodule

@@ src/per_source_credit_admission_unit.sv @@
// top level of the per-source credit admission unit
//
// requests enter on req_i and are transferred at a rising edge with start_i
// high and busy_o low; busy_o stays low, so a request can be given every cycle
// each request is an operation (query, reserve, release), a direction, a
// source and a burst beat count
// a request is held in an input register while the checks and counter updates
// run against the current counters; the counters and the result register load
// at the next edge, so a request sees the effect of the one before it
// the result appears on rsp_o with valid_o high for exactly one cycle, after
// the input register and the result register (throughput one per cycle)
// the receiver has no way to stall; a result not taken in its cycle is gone
// capacities and per-source limits are written through cfg_we_i, cfg_idx_i and
// cfg_data_i; the user must write them only while no request is in flight, as
// the block itself does not enforce this; reset clears all counters and
// pipeline valids and loads the default capacities and limits
module per_source_credit_admission_unit import psca_pkg::*; #(
  parameter int NUM_SOURCES = 4,
  parameter int BEAT_BITS   = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  psca_req_t             req_i,
  output logic                  valid_o,
  output psca_rsp_t             rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic                 req_valid_q;
  psca_req_t            req_q;
  logic                 rsp_valid_q;
  psca_rsp_t            rsp_q;

  logic [CTX_W-1:0]     cap_ctx, lim_ctx, g_ctx, a_ctx;
  logic [GBEAT_W-1:0]   cap_beats, g_beats;
  logic [BEAT_BITS-1:0] lim_beats, a_beats;
  psca_rsp_t            rsp_d;
  psca_upd_t            upd;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      req_valid_q <= start_i && !busy_o;
      rsp_valid_q <= req_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      req_q <= req_i;
    end
    if (req_valid_q) begin
      rsp_q <= rsp_d;
    end
  end

  psca_cfg #(
    .NUM_SOURCES(NUM_SOURCES),
    .BEAT_BITS  (BEAT_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .is_read_i  (req_q.is_read),
    .source_i   (req_q.source_index),
    .cap_ctx_o  (cap_ctx),
    .cap_beats_o(cap_beats),
    .lim_ctx_o  (lim_ctx),
    .lim_beats_o(lim_beats)
  );

  psca_cnt #(
    .NUM_SOURCES(NUM_SOURCES),
    .BEAT_BITS  (BEAT_BITS)
  ) u_cnt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .is_read_i(req_q.is_read),
    .source_i (req_q.source_index),
    .upd_i    (upd),
    .g_ctx_o  (g_ctx),
    .g_beats_o(g_beats),
    .a_ctx_o  (a_ctx),
    .a_beats_o(a_beats)
  );

  psca_dec #(
    .NUM_SOURCES(NUM_SOURCES),
    .BEAT_BITS  (BEAT_BITS)
  ) u_dec (
    .valid_i    (req_valid_q),
    .req_i      (req_q),
    .g_ctx_i    (g_ctx),
    .g_beats_i  (g_beats),
    .a_ctx_i    (a_ctx),
    .a_beats_i  (a_beats),
    .cap_ctx_i  (cap_ctx),
    .cap_beats_i(cap_beats),
    .lim_ctx_i  (lim_ctx),
    .lim_beats_i(lim_beats),
    .rsp_o      (rsp_d),
    .upd_o      (upd)
  );

  assign valid_o = rsp_valid_q;
  assign rsp_o   = rsp_q;

endmodule

@@ src/psca_chk.sv @@
// port-level checks of the per-source credit admission unit and their bind
module psca_chk import psca_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input psca_req_t req_i,
  input logic      valid_o,
  input psca_rsp_t rsp_o
);

  logic xfer;

  assign xfer = start_i && !busy_o;

  // one result after every request transfer, through the input and result registers
  a_latency_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |-> ##2 valid_o)
    else $error("missing result two cycles after a request transfer");

  a_latency_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !xfer |-> ##2 !valid_o)
    else $error("result without a matching request transfer");

  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (rsp_o.granted == (rsp_o.status == ST_OK)))
    else $error("granted and status disagree");

  a_release_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && req_i.operation == OP_RELEASE |-> ##2 (rsp_o.status != ST_OVER_LIMIT))
    else $error("release reported active above limit");

  a_admit_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && (req_i.operation == OP_QUERY || req_i.operation == OP_RESERVE)
      |-> ##2 (rsp_o.status != ST_UNDERFLOW))
    else $error("query or reserve reported release underflow");

endmodule

bind per_source_credit_admission_unit psca_chk u_psca_chk (.*);
